@@ design/ugmd_pkg.sv @@
// Package with the types, constants and helper functions of the guarded motor drive.
package ugmd_pkg;

  // Default sizes of the block.
  localparam int SENSORS_DEF = 3;
  localparam int WHEELS_DEF  = 4;

  // Saturation limits of the channel counters.
  localparam logic [19:0] TIMER_MAX = 20'hFFFFF;
  localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

  // Echo microseconds per centimetre, and its reciprocal scaled by 2^20.
  localparam logic [16:0] CM_DIV   = 17'd58;
  localparam logic [14:0] CM_RECIP = 15'd18079;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DUTY     = 3'd0;
  localparam logic [2:0] CFG_PERIOD   = 3'd1;
  localparam logic [2:0] CFG_MIN_DIST = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_MOVE     = 3'd4;
  localparam logic [2:0] CFG_INTERVAL = 3'd5;
  localparam logic [2:0] CFG_TRIGGER  = 3'd6;

  // Register reset values.
  localparam logic [6:0]  DUTY_RST     = 7'd40;
  localparam logic [6:0]  PERIOD_RST   = 7'd100;
  localparam logic [9:0]  MIN_DIST_RST = 10'd10;
  localparam logic [15:0] TIMEOUT_RST  = 16'd50000;
  localparam logic [23:0] MOVE_RST     = 24'd5000000;
  localparam logic [19:0] INTERVAL_RST = 20'd100000;
  localparam logic [7:0]  TRIGGER_RST  = 8'd10;

  // Motion command bytes.
  localparam logic [7:0] CMD_FORWARD = 8'h46;
  localparam logic [7:0] CMD_BACK    = 8'h4E;
  localparam logic [7:0] CMD_LEFT    = 8'h4C;
  localparam logic [7:0] CMD_RIGHT   = 8'h52;
  localparam logic [7:0] CMD_SPIN_V  = 8'h56;
  localparam logic [7:0] CMD_SPIN_B  = 8'h42;

  // Phases of one ranging channel.
  typedef enum logic [1:0] {
    PH_PAUSE   = 2'd0,
    PH_TRIGGER = 2'd1,
    PH_WAIT    = 2'd2,
    PH_TIMING  = 2'd3
  } ch_phase_t;

  // One input tick.
  typedef struct packed {
    logic [2:0] echo_levels;
    logic       command_valid;
    logic [7:0] command_byte;
  } in_t;

  // One result tick.
  typedef struct packed {
    logic [7:0] motor_pins;
    logic [2:0] trigger_pins;
    logic [2:0] done_mask;
    logic [2:0] error_mask;
    logic [9:0] distance_a;
    logic [9:0] distance_b;
    logic [9:0] distance_c;
    logic       moving;
    logic       obstacle_halt;
  } out_t;

  // Wheel pattern of a command byte; bit 8 is set when the byte is a known command.
  function automatic logic [8:0] pattern_of(input logic [7:0] cmd);
    logic [8:0] res;
    unique case (cmd)
      CMD_FORWARD: res = {1'b1, 8'h55};
      CMD_BACK:    res = {1'b1, 8'hAA};
      CMD_LEFT:    res = {1'b1, 8'h50};
      CMD_RIGHT:   res = {1'b1, 8'h05};
      CMD_SPIN_V:  res = {1'b1, 8'h96};
      CMD_SPIN_B:  res = {1'b1, 8'h69};
      default:     res = 9'd0;
    endcase
    return res;
  endfunction

  // Echo width in whole centimetres, saturated at 1023; an error reads as zero.
  // The reciprocal product is exact for every 16-bit width.
  function automatic logic [9:0] cm_of(input logic [15:0] w, input logic err);
    logic [31:0] scaled;
    logic [10:0] q;
    logic [9:0]  res;
    scaled = 32'(w) * 32'(CM_RECIP);
    q      = scaled[30:20];
    if (err) begin
      res = 10'd0;
    end else if (q > 11'd1023) begin
      res = 10'd1023;
    end else begin
      res = q[9:0];
    end
    return res;
  endfunction

endpackage

@@ design/ultrasonic_guarded_motor_drive_top.sv @@
// Top level of the ultrasonic-guarded motor drive: ranging channels, PWM drive and obstacle stop.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall     in_data  (ugmd_pkg::in_t, one microsecond tick)
//   output    out_valid / out_stall   out_data (ugmd_pkg::out_t, one result per tick)
//   config    wr_en                   wr_index, wr_data (24 bits, masked per register)
//
// One tick is taken per cycle unless stalled; its result is registered in out_data or skid_data.
// The whole tick update is one pass of logic from the state registers to the result register.
// Reset is synchronous: all but the payload registers take reset values; no result is pending.
// A stalled result is held, and a second tick is kept in a skid register; the input
// stalls only while that skid register is full.
module ultrasonic_guarded_motor_drive_top #(
  parameter int SENSORS = ugmd_pkg::SENSORS_DEF,
  parameter int WHEELS  = ugmd_pkg::WHEELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ugmd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ugmd_pkg::out_t out_data,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [23:0]   wr_data
);
  import ugmd_pkg::*;

  localparam int MODE_BITS = (2 * WHEELS > 8) ? 8 : 2 * WHEELS;

  // Configuration registers; the distance limit is kept as an echo width threshold.
  logic [6:0]  duty_ticks;
  logic [6:0]  pwm_period_ticks;
  logic [16:0] min_width;
  logic [15:0] echo_timeout_us;
  logic [23:0] move_duration_us;
  logic [19:0] measure_interval_us;
  logic [7:0]  trigger_width_us;

  // Drive state.
  logic [6:0]           pwm_phase, pwm_phase_next;
  logic [MODE_BITS-1:0] wheel_modes, wheel_modes_next;
  logic [23:0]          motion_timer, motion_timer_next;

  // Ranging channel state.
  ch_phase_t   channel_phase [SENSORS];
  ch_phase_t   channel_phase_next [SENSORS];
  logic [19:0] channel_timer [SENSORS];
  logic [19:0] channel_timer_next [SENSORS];
  logic [15:0] echo_width [SENSORS];
  logic [15:0] echo_width_next [SENSORS];
  logic [15:0] reading_width [SENSORS];
  logic [15:0] reading_width_next [SENSORS];
  logic        reading_err [SENSORS];
  logic        reading_err_next [SENSORS];

  // Output register and skid register.
  out_t result;
  out_t skid_data;
  logic skid_valid;
  logic accept;
  logic take;

  // Per-tick intermediate values.
  logic [SENSORS-1:0] echo_vec;
  logic [SENSORS-1:0] trig_vec;
  logic [SENSORS-1:0] fin_vec;
  logic [SENSORS-1:0] bad_vec;
  logic [SENSORS-1:0] obs_old;
  logic [SENSORS-1:0] obs_new;
  logic [8:0]         pattern;
  logic [6:0]         period;
  logic [7:0]         trig_len;
  logic [7:0]         phase_inc;
  logic [MODE_BITS-1:0] wheel_cmd;
  logic [23:0]        motion_cmd;
  logic               halt;
  logic               seen;
  logic [MODE_BITS-1:0] wheel_halt;
  logic [23:0]        motion_halt;
  logic [MODE_BITS-1:0] pins;
  logic [9:0]         dist_cm [3];

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;
  assign echo_vec = SENSORS'(in_data.echo_levels);

  // Ranging channels: pause, trigger, wait for echo, time echo.
  always_comb begin
    logic [19:0] tu;
    logic        high;
    trig_len = (trigger_width_us == 8'd0) ? 8'd1 : trigger_width_us;
    for (int k = 0; k < SENSORS; k++) begin
      tu   = (channel_timer[k] == TIMER_MAX) ? TIMER_MAX : channel_timer[k] + 20'd1;
      high = echo_vec[k];
      trig_vec[k]              = (channel_phase[k] == PH_TRIGGER);
      fin_vec[k]               = 1'b0;
      bad_vec[k]               = 1'b0;
      channel_phase_next[k]    = channel_phase[k];
      channel_timer_next[k]    = tu;
      echo_width_next[k]       = echo_width[k];
      reading_width_next[k]    = reading_width[k];
      reading_err_next[k]      = reading_err[k];
      unique case (channel_phase[k])
        PH_PAUSE: begin
          if (channel_timer[k] >= measure_interval_us) begin
            channel_phase_next[k] = PH_TRIGGER;
            channel_timer_next[k] = 20'd0;
          end
        end
        PH_TRIGGER: begin
          if (tu >= 20'(trig_len)) begin
            channel_phase_next[k] = PH_WAIT;
            channel_timer_next[k] = 20'd0;
          end
        end
        PH_WAIT: begin
          if (high) begin
            channel_phase_next[k] = PH_TIMING;
            echo_width_next[k]    = 16'd1;
          end else if (tu > 20'(echo_timeout_us)) begin
            fin_vec[k] = 1'b1;
            bad_vec[k] = 1'b1;
          end
        end
        PH_TIMING: begin
          if (!high) begin
            fin_vec[k] = 1'b1;
          end else if (tu > 20'(echo_timeout_us)) begin
            fin_vec[k] = 1'b1;
            bad_vec[k] = 1'b1;
          end else if (echo_width[k] != WIDTH_MAX) begin
            echo_width_next[k] = echo_width[k] + 16'd1;
          end
        end
        default: begin
          channel_phase_next[k] = PH_PAUSE;
        end
      endcase
      // A finished measurement stores its reading and restarts the channel.
      if (fin_vec[k]) begin
        reading_width_next[k] = bad_vec[k] ? WIDTH_MAX : echo_width[k];
        reading_err_next[k]   = bad_vec[k];
        channel_phase_next[k] = PH_PAUSE;
        channel_timer_next[k] = 20'd0;
        echo_width_next[k]    = 16'd0;
      end
      obs_old[k] = reading_err[k] || (17'(reading_width[k]) < min_width);
      obs_new[k] = reading_err_next[k] || (17'(reading_width_next[k]) < min_width);
    end
  end

  // Command, obstacle stop, pin drive and timers.
  always_comb begin
    pattern    = pattern_of(in_data.command_byte);
    wheel_cmd  = wheel_modes;
    motion_cmd = motion_timer;
    if (in_data.command_valid && pattern[8]) begin
      wheel_cmd  = pattern[MODE_BITS-1:0];
      motion_cmd = (move_duration_us == 24'd0) ? 24'd1 : move_duration_us;
    end

    // Each finished channel checks the readings stored up to and including itself.
    halt = 1'b0;
    for (int k = 0; k < SENSORS; k++) begin
      seen = 1'b0;
      for (int j = 0; j < SENSORS; j++) begin
        seen = seen || ((j <= k) ? obs_new[j] : obs_old[j]);
      end
      halt = halt || (fin_vec[k] && seen);
    end
    halt = halt && (motion_cmd != 24'd0);

    wheel_halt  = halt ? '0 : wheel_cmd;
    motion_halt = halt ? 24'd0 : motion_cmd;
    pins = ((motion_halt != 24'd0) && (pwm_phase < duty_ticks)) ? wheel_halt : '0;

    motion_timer_next = (motion_halt != 24'd0) ? motion_halt - 24'd1 : 24'd0;
    wheel_modes_next  = (motion_halt == 24'd1) ? '0 : wheel_halt;

    period         = (pwm_period_ticks == 7'd0) ? 7'd1 : pwm_period_ticks;
    phase_inc      = 8'(pwm_phase) + 8'd1;
    pwm_phase_next = (phase_inc >= 8'(period)) ? 7'd0 : phase_inc[6:0];
  end

  // Distances of the three reported sensors; absent sensors read zero.
  for (genvar g = 0; g < 3; g++) begin : g_dist
    if (g < SENSORS) begin : g_on
      assign dist_cm[g] = cm_of(reading_width_next[g], reading_err_next[g]);
    end else begin : g_off
      assign dist_cm[g] = 10'd0;
    end
  end

  // Result of the current tick.
  always_comb begin
    result.motor_pins    = 8'(pins);
    result.trigger_pins  = 3'(trig_vec);
    result.done_mask     = 3'(fin_vec);
    result.error_mask    = 3'(bad_vec);
    result.distance_a    = dist_cm[0];
    result.distance_b    = dist_cm[1];
    result.distance_c    = dist_cm[2];
    result.moving        = (motion_halt != 24'd0);
    result.obstacle_halt = halt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_ticks          <= DUTY_RST;
      pwm_period_ticks    <= PERIOD_RST;
      min_width           <= 17'(MIN_DIST_RST) * CM_DIV;
      echo_timeout_us     <= TIMEOUT_RST;
      move_duration_us    <= MOVE_RST;
      measure_interval_us <= INTERVAL_RST;
      trigger_width_us    <= TRIGGER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DUTY:     duty_ticks          <= wr_data[6:0];
        CFG_PERIOD:   pwm_period_ticks    <= wr_data[6:0];
        CFG_MIN_DIST: min_width           <= 17'(wr_data[9:0]) * CM_DIV;
        CFG_TIMEOUT:  echo_timeout_us     <= wr_data[15:0];
        CFG_MOVE:     move_duration_us    <= wr_data[23:0];
        CFG_INTERVAL: measure_interval_us <= wr_data[19:0];
        CFG_TRIGGER:  trigger_width_us    <= wr_data[7:0];
        default:      ;
      endcase
    end
  end

  // Tick state advances on every accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase    <= 7'd0;
      wheel_modes  <= '0;
      motion_timer <= 24'd0;
      for (int k = 0; k < SENSORS; k++) begin
        channel_phase[k] <= PH_PAUSE;
        channel_timer[k] <= 20'd0;
        echo_width[k]    <= 16'd0;
        reading_width[k] <= WIDTH_MAX;
        reading_err[k]   <= 1'b0;
      end
    end else if (accept) begin
      pwm_phase    <= pwm_phase_next;
      wheel_modes  <= wheel_modes_next;
      motion_timer <= motion_timer_next;
      for (int k = 0; k < SENSORS; k++) begin
        channel_phase[k] <= channel_phase_next[k];
        channel_timer[k] <= channel_timer_next[k];
        echo_width[k]    <= echo_width_next[k];
        reading_width[k] <= reading_width_next[k];
        reading_err[k]   <= reading_err_next[k];
      end
    end
  end

  // Output and skid valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payloads; the skid entry is older than a new transfer.
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

@@ design/ugmd_checker.sv @@
// Port checker of the guarded motor drive, bound to the top level.
module ugmd_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input ugmd_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input ugmd_pkg::out_t out_data,
  input logic          wr_en,
  input logic [2:0]    wr_index,
  input logic [23:0]   wr_data
);
  import ugmd_pkg::*;

  // A stalled result stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A timeout is only reported for a channel that finished on that tick.
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.error_mask & ~out_data.done_mask) == 3'd0)
    else $error("error without finished measurement");

  // An obstacle stop leaves the motors stopped on that tick.
  a_halt_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.obstacle_halt |->
      !out_data.moving && out_data.motor_pins == 8'd0 && out_data.done_mask != 3'd0)
    else $error("obstacle stop with motors driven");

  // Motor pins are only driven during a motion.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.moving |-> out_data.motor_pins == 8'd0)
    else $error("motor pins driven while idle");

  // No result is pending straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind ultrasonic_guarded_motor_drive_top ugmd_checker u_ugmd_checker (.*);
